[hdl/assert_macros.svh]
// Assertion macros shared by the checker files of this block.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

// Condition that must hold in the cycle after reset is seen.
`define ASSERT_AFTER_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("post-reset condition failed");

`endif

[hdl/lfbg_pkg.sv]
// Shared constants, types and word functions of the lagged Fibonacci byte generator.
// No dependencies.
package lfbg_pkg;

   localparam int TABLE_WORDS   = 521;
   localparam int SHORT_LAG     = 32;
   localparam int SEED_WORDS    = 17;
   localparam int TABLE_BYTES   = TABLE_WORDS * 4;
   localparam int MAX_EMIT      = 64;
   localparam int COMMIT_PASSES = 4;

   localparam int WORD_W = 32;
   localparam int BYTE_W = 8;
   localparam int ADDR_W = $clog2(TABLE_WORDS + 1);
   localparam int POS_W  = $clog2(TABLE_BYTES);
   localparam int IDX_W  = 5;
   localparam int CNT_W  = 7;
   localparam int ACT_W  = 2;
   localparam int PASS_W = $clog2(COMMIT_PASSES + 1);

   // request tdata layout, lowest bit first
   localparam int REQ_IDX_LSB  = 0;
   localparam int REQ_WORD_LSB = REQ_IDX_LSB + IDX_W;
   localparam int REQ_CNT_LSB  = REQ_WORD_LSB + WORD_W;
   localparam int REQ_DATA_W   = ((REQ_CNT_LSB + CNT_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = BYTE_W;

   // seed expansion recurrence
   localparam int EXP_SHL = 23;
   localparam int EXP_SHR = 9;

   // bits 18..25 folded down to 16..23
   localparam logic [WORD_W-1:0] FIX_KEEP_MASK = 32'hFF00FFFF;
   localparam logic [WORD_W-1:0] FIX_MOVE_MASK = 32'h00FF0000;
   localparam int                FIX_SHIFT     = 2;

   typedef enum logic [ACT_W-1:0] {
      ACT_SEED   = 2'd0,
      ACT_COMMIT = 2'd1,
      ACT_EMIT   = 2'd2
   } action_type;

   typedef struct packed {
      logic              seed_wr;
      logic              load_push;
      logic              exp_step;
      logic              lag_wr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
      logic [ADDR_W-1:0] wr_addr;
      logic              emit;
      logic [1:0]        byte_sel;
      logic              last;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_stat_type;

   function automatic logic [WORD_W-1:0] bswap32(input logic [WORD_W-1:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

   function automatic logic [WORD_W-1:0] fix_word(input logic [WORD_W-1:0] w);
      return bswap32((w & FIX_KEEP_MASK) | ((w >> FIX_SHIFT) & FIX_MOVE_MASK));
   endfunction

endpackage

[hdl/lfbg_ctrl.sv]
// Sequencer of the lagged Fibonacci byte generator: seeding, expansion, lag passes, emit.
// Depends on lfbg_pkg; drives the datapath through dp_cmd_type.
module lfbg_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lfbg_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [lfbg_pkg::ACT_W-1:0]         req_tuser,
   output lfbg_pkg::dp_cmd_type               cmd,
   input  lfbg_pkg::dp_stat_type              stat
);
   import lfbg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_EXPAND,
      ST_LAG,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [PASS_W-1:0]  passes_ff, passes_in;

   logic [IDX_W-1:0]   seed_index;
   logic [CNT_W-1:0]   byte_count;
   action_type         act;

   assign seed_index = req_tdata[REQ_IDX_LSB +: IDX_W];
   assign byte_count = req_tdata[REQ_CNT_LSB +: CNT_W];
   assign act        = action_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      rem_in    = rem_ff;
      passes_in = passes_ff;
      cmd       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (act)
                  ACT_SEED: begin
                     if (seed_index < IDX_W'(SEED_WORDS)) begin
                        cmd.seed_wr = 1'b1;
                        cmd.wr_addr = ADDR_W'(seed_index);
                     end
                  end
                  ACT_COMMIT: begin
                     state_in  = ST_LOAD;
                     idx_in    = '0;
                     pos_in    = '0;
                     rem_in    = '0;
                     passes_in = PASS_W'(COMMIT_PASSES);
                  end
                  ACT_EMIT: begin
                     if (byte_count != '0) begin
                        rem_in   = (byte_count > CNT_W'(MAX_EMIT)) ? CNT_W'(MAX_EMIT)
                                                                 : byte_count;
                        state_in = ST_EMIT_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // read raw seeds into the window, write each back in final form
         ST_LOAD: begin
            cmd.rd_en     = (idx_ff < ADDR_W'(SEED_WORDS));
            cmd.rd_addr_a = idx_ff;
            if (idx_ff != '0) begin
               cmd.load_push = 1'b1;
               cmd.wr_addr   = idx_ff - ADDR_W'(1);
            end
            if (idx_ff == ADDR_W'(SEED_WORDS)) begin
               state_in = ST_EXPAND;
            end else begin
               idx_in = idx_ff + ADDR_W'(1);
            end
         end

         ST_EXPAND: begin
            cmd.exp_step = 1'b1;
            cmd.wr_addr  = idx_ff;
            if (idx_ff == ADDR_W'(TABLE_WORDS - 1)) begin
               state_in = ST_LAG;
               idx_in   = '0;
            end else begin
               idx_in = idx_ff + ADDR_W'(1);
            end
         end

         // read word i and its partner, write the xor in the cycle after
         ST_LAG: begin
            if (idx_ff < ADDR_W'(TABLE_WORDS)) begin
               cmd.rd_en     = 1'b1;
               cmd.rd_addr_a = idx_ff;
               cmd.rd_addr_b = (idx_ff < ADDR_W'(SHORT_LAG))
                             ? idx_ff + ADDR_W'(TABLE_WORDS - SHORT_LAG)
                             : idx_ff - ADDR_W'(SHORT_LAG);
            end
            if (idx_ff != '0) begin
               cmd.lag_wr  = 1'b1;
               cmd.wr_addr = idx_ff - ADDR_W'(1);
            end
            if (idx_ff == ADDR_W'(TABLE_WORDS)) begin
               idx_in    = '0;
               passes_in = passes_ff - PASS_W'(1);
               if (passes_ff == PASS_W'(1)) begin
                  state_in = (rem_ff != '0) ? ST_EMIT_RD : ST_IDLE;
               end
            end else begin
               idx_in = idx_ff + ADDR_W'(1);
            end
         end

         ST_EMIT_RD: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_addr_a = ADDR_W'(pos_ff[POS_W-1:2]);
            state_in      = ST_EMIT_OUT;
         end

         ST_EMIT_OUT: begin
            if (stat.out_free) begin
               cmd.emit     = 1'b1;
               cmd.byte_sel = pos_ff[1:0];
               cmd.last     = (rem_ff == CNT_W'(1));
               rem_in       = rem_ff - CNT_W'(1);
               if (pos_ff == POS_W'(TABLE_BYTES - 1)) begin
                  pos_in    = '0;
                  idx_in    = '0;
                  passes_in = PASS_W'(1);
                  state_in  = ST_LAG;
               end else begin
                  pos_in   = pos_ff + POS_W'(1);
                  state_in = (rem_ff == CNT_W'(1)) ? ST_IDLE : ST_EMIT_RD;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         idx_ff    <= '0;
         pos_ff    <= '0;
         rem_ff    <= '0;
         passes_ff <= '0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         pos_ff    <= pos_in;
         rem_ff    <= rem_in;
         passes_ff <= passes_in;
      end
   end

endmodule

[hdl/lfbg_dpath.sv]
// Datapath of the lagged Fibonacci byte generator: lag table, seed window, output register.
// Depends on lfbg_pkg; commanded by lfbg_ctrl.
module lfbg_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  lfbg_pkg::dp_cmd_type               cmd,
   output lfbg_pkg::dp_stat_type              stat,
   input  logic [lfbg_pkg::WORD_W-1:0]        seed_word,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lfbg_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast
);
   import lfbg_pkg::*;

   logic [WORD_W-1:0] table_mem [TABLE_WORDS];
   logic [WORD_W-1:0] rd_a_ff, rd_b_ff;
   logic [WORD_W-1:0] win_ff [SEED_WORDS];

   logic [WORD_W-1:0] exp_word, win_in, wr_data;
   logic              wr_en, win_shift;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff;

   // t[i] = t[i-17] << 23 ^ t[i-16] >> 9 ^ t[i-1]
   assign exp_word = (win_ff[0] << EXP_SHL) ^ (win_ff[1] >> EXP_SHR)
                   ^ win_ff[SEED_WORDS-1];

   assign win_shift = cmd.load_push | cmd.exp_step;
   assign win_in    = cmd.load_push ? rd_a_ff : exp_word;
   assign wr_en     = cmd.seed_wr | cmd.load_push | cmd.exp_step | cmd.lag_wr;

   always_comb begin
      priority if (cmd.seed_wr) begin
         wr_data = bswap32(seed_word);
      end else if (cmd.load_push) begin
         wr_data = fix_word(rd_a_ff);
      end else if (cmd.exp_step) begin
         wr_data = fix_word(exp_word);
      end else begin
         wr_data = rd_a_ff ^ rd_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[cmd.wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_a_ff <= table_mem[cmd.rd_addr_a];
         rd_b_ff <= table_mem[cmd.rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (win_shift) begin
         for (int k = 0; k < SEED_WORDS - 1; k++) begin
            win_ff[k] <= win_ff[k+1];
         end
         win_ff[SEED_WORDS-1] <= win_in;
      end
   end

   // little-endian byte pick from the word just read
   assign rsp_data_in  = BYTE_W'(rd_a_ff >> {cmd.byte_sel, 3'b000});
   assign stat.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in  = cmd.emit | (rsp_valid_ff & !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= cmd.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[hdl/lagged_fibonacci_byte_generator.sv]
// Lagged Fibonacci junk-fill byte generator, top level: lfbg_ctrl plus lfbg_dpath.
// Emit: each byte takes a table read (ST_EMIT_RD) and then an output register load (ST_EMIT_OUT);
// the load waits while the output register is full and stalled. Each table wrap adds one
// lag pass. Commit loads the 17 seeds, expands the table and runs four lag passes.
// Reset: synchronous, active high; clears the sequencer, byte position and output valid.
// The lag table is not cleared and must be seeded and committed before emitting.
module lagged_fibonacci_byte_generator (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata, lowest bit up: seed_index[4:0], seed_word[36:5], byte_count[43:37], zero pad
   input  logic [lfbg_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: action (0 seed write, 1 commit, 2 emit)
   input  logic [lfbg_pkg::ACT_W-1:0]         req_tuser,
   // response channel, one beat per byte
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: out_byte[7:0]
   output logic [lfbg_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // tlast: last_byte, final byte of an emit request
   output logic                               rsp_tlast
);
   import lfbg_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // The controller owns all counters: table index, byte position, bytes still owed
   // and lag passes left. Requests are taken only while it sits idle.
   lfbg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

   // The datapath holds the 521-word table (one write, two registered reads per
   // cycle), the 17-word expansion window and the output register. The output
   // register decouples the sinks stall from the sequencer: a byte waits there
   // while the next table word is already being fetched.
   lfbg_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .seed_word  (req_tdata[REQ_WORD_LSB +: WORD_W]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[hdl/lfbg_checker.sv]
// Port-level assertions for lagged_fibonacci_byte_generator, bound to the top level.
// Depends on lfbg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lfbg_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [lfbg_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [lfbg_pkg::ACT_W-1:0]         req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [lfbg_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               rsp_tlast
);
   import lfbg_pkg::*;

   logic req_beat;
   assign req_beat = req_tvalid && req_tready;

   // stalled byte holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   `ASSERT_AFTER_RESET(a_rsp_reset, clock, reset, !rsp_tvalid)

   // a burst in flight keeps the request side closed
   `ASSERT_IMPLY(a_burst_busy, clock, reset, rsp_tvalid && !rsp_tlast, !req_tready)

   `ASSERT_NEXT(a_commit_busy, clock, reset, req_beat && req_tuser == ACT_COMMIT, !req_tready)

   `ASSERT_NEXT(a_emit_busy, clock, reset, req_beat && req_tuser == ACT_EMIT && req_tdata[REQ_CNT_LSB +: CNT_W] != '0, !req_tready)

endmodule

bind lagged_fibonacci_byte_generator lfbg_checker u_lfbg_checker (.*);

[sim/testbench.sv]
// Self-checking bench for lagged_fibonacci_byte_generator: seed writes, commits and emits,
// checked byte by byte against a predictor of the fill table kept in the bench.
// Depends on lfbg_pkg (port widths, action names) and the generator RTL.
module testbench;

   localparam int CLK_HALF      = 4;
   localparam int FILL_WORDS    = 521;
   localparam int LAG_SHORT     = 32;
   localparam int SEED_COUNT    = 17;
   localparam int FILL_BYTES    = FILL_WORDS * 4;
   localparam int EMIT_LIMIT    = 64;
   localparam int COMMIT_LAGS   = 4;
   localparam logic [31:0] KEEP_BITS = 32'hFF00FFFF;
   localparam logic [31:0] FOLD_BITS = 32'h00FF0000;
   // action code the block has no use for
   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int MIX_ITEMS     = 240;
   // wait at the end for longer than a commit in flight takes
   localparam int SETTLE_CYCLES = 3000;
   localparam int LOG_LIMIT     = 30;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } fill_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // tdata, lowest bit up: seed_index[4:0], seed_word[36:5], byte_count[43:37], zero pad
   logic [lfbg_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   // tuser: action
   logic [lfbg_pkg::ACT_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // tdata: out_byte[7:0]
   logic [lfbg_pkg::RSP_DATA_W-1:0] rsp_tdata;
   // tlast: last_byte
   logic rsp_tlast;

   // predictor state: the fill table, the read position and the bytes still owed
   logic [31:0]    fill_table [FILL_WORDS];
   int unsigned    fill_pos = 0;
   fill_byte_type  expected_fill_bytes [$];
   fill_byte_type  fill_head;

   bit no_idle = 1'b0;
   int error_count = 0;
   int beats_sent = 0;
   int emits_sent = 0;
   int commits_sent = 0;
   int table_wraps = 0;
   int bytes_checked = 0;

   lagged_fibonacci_byte_generator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #CLK_HALF clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic logic [31:0] swap_word(input logic [31:0] w);
      logic [31:0] r;
      for (int b = 0; b < 4; b++) r[8*b +: 8] = w[8*(3-b) +: 8];
      return r;
   endfunction

   // one xor pass with lags 32 and 521; the first 32 words reach around the end
   function automatic void run_lag_pass();
      for (int i = 0; i < LAG_SHORT; i++)
         fill_table[i] ^= fill_table[i + FILL_WORDS - LAG_SHORT];
      for (int i = LAG_SHORT; i < FILL_WORDS; i++)
         fill_table[i] ^= fill_table[i - LAG_SHORT];
   endfunction

   function automatic void expand_fill_table();
      logic [31:0] w;
      // shift-xor recurrence over the 17 seed words
      for (int i = SEED_COUNT; i < FILL_WORDS; i++)
         fill_table[i] = (fill_table[i-17] << 23) ^ (fill_table[i-16] >> 9) ^ fill_table[i-1];
      // bits 18..25 drop onto 16..23, then each word is byte swapped
      for (int i = 0; i < FILL_WORDS; i++) begin
         w = fill_table[i];
         fill_table[i] = swap_word((w & KEEP_BITS) | ((w >> 2) & FOLD_BITS));
      end
      repeat (COMMIT_LAGS) run_lag_pass();
      fill_pos = 0;
   endfunction

   function automatic void predict_fill_bytes(input logic [1:0] act, input logic [4:0] idx,
                                              input logic [31:0] word,
                                              input logic [6:0] count);
      int n;
      fill_byte_type b;
      logic [31:0] w;
      case (act)
         lfbg_pkg::ACT_SEED: begin
            if (idx < SEED_COUNT) fill_table[idx] = swap_word(word);
         end
         lfbg_pkg::ACT_COMMIT: begin
            expand_fill_table();
         end
         lfbg_pkg::ACT_EMIT: begin
            // oversized requests clamp to 64 bytes, zero gives nothing
            n = (count > EMIT_LIMIT) ? EMIT_LIMIT : count;
            for (int k = 0; k < n; k++) begin
               w = fill_table[fill_pos / 4] >> (8 * (fill_pos % 4));
               b.value = w[7:0];
               b.last  = (k == n - 1);
               expected_fill_bytes.push_back(b);
               fill_pos++;
               if (fill_pos == FILL_BYTES) begin
                  run_lag_pass();
                  fill_pos = 0;
                  table_wraps++;
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- pacing and checking

   // mostly no gap, often a short one, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // result side: ready runs of random length broken by stalls
   initial begin : rsp_pacing
      int busy;
      int stall;
      forever begin
         busy = $urandom_range(1, 24);
         @(posedge clock);
         rsp_tready <= 1'b1;
         repeat (busy - 1) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            @(posedge clock);
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(posedge clock);
         end
      end
   end

   task automatic report_mismatch(input string what);
      if (error_count < LOG_LIMIT) $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   // every accepted byte beat is matched against the oldest expected byte
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         bytes_checked++;
         if (expected_fill_bytes.size() == 0) begin
            report_mismatch($sformatf("byte 0x%02h arrived with nothing expected", rsp_tdata));
         end else begin
            fill_head = expected_fill_bytes.pop_front();
            if (rsp_tdata !== fill_head.value)
               report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                                         rsp_tdata, fill_head.value));
            if (rsp_tlast !== fill_head.last)
               report_mismatch($sformatf("last_byte %b, expected %b",
                                         rsp_tlast, fill_head.last));
         end
      end
   end

   // ---------------------------------------------------------------- request side

   // valid stays high into the next call when no gap is drawn; callers that wait
   // for anything else go through wait_drained, which lowers it first
   task automatic send_request(input logic [1:0] act, input logic [4:0] idx,
                               input logic [31:0] word, input logic [6:0] count);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {{(lfbg_pkg::REQ_DATA_W - 44){1'b0}}, count, word, idx};
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_fill_bytes(act, idx, word, count);
      beats_sent++;
      if (act == lfbg_pkg::ACT_EMIT) emits_sent++;
      if (act == lfbg_pkg::ACT_COMMIT) commits_sent++;
   endtask

   // unused fields of each beat carry random junk
   task automatic write_seed(input logic [4:0] idx, input logic [31:0] word);
      send_request(lfbg_pkg::ACT_SEED, idx, word, 7'($urandom_range(0, 127)));
   endtask

   task automatic commit_seed();
      send_request(lfbg_pkg::ACT_COMMIT, 5'($urandom_range(0, 31)), $urandom,
                   7'($urandom_range(0, 127)));
   endtask

   task automatic emit_bytes(input logic [6:0] count);
      send_request(lfbg_pkg::ACT_EMIT, 5'($urandom_range(0, 31)), $urandom, count);
   endtask

   // hold off new beats until every owed byte has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_fill_bytes.size() != 0);
   endtask

   // full seed set followed by a commit; extremes puts all-zero and all-one words at the ends
   task automatic reseed_table(input bit extremes);
      logic [31:0] word;
      for (int i = 0; i < SEED_COUNT; i++) begin
         word = $urandom;
         if (extremes && i == 0) word = '0;
         if (extremes && i == SEED_COUNT - 1) word = '1;
         write_seed(5'(i), word);
      end
      commit_seed();
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      reseed_table(1'b1);
      // out-of-range index: must not touch the table
      write_seed(5'd31, '1);
      // unused action with every field bit set: no bytes
      send_request(ACT_UNUSED, '1, '1, '1);
      emit_bytes(1);
      emit_bytes(7'(EMIT_LIMIT));
      // empty emit, then two oversized ones that clamp to 64
      emit_bytes(0);
      emit_bytes(7'd127);
      emit_bytes(7'(EMIT_LIMIT + 1));
   endtask

   // stream through the end of the table twice so the refresh pass runs;
   // the first lap without any idling on either side
   task automatic test_long_stream();
      int start_wraps;
      start_wraps = table_wraps;
      no_idle = 1'b1;
      while (table_wraps < start_wraps + 1) emit_bytes(7'($urandom_range(32, EMIT_LIMIT)));
      no_idle = 1'b0;
      while (table_wraps < start_wraps + 2) emit_bytes(7'($urandom_range(16, EMIT_LIMIT)));
      wait_drained();
   endtask

   // mostly emits, with seed rewrites, recommits, full reseeds, drain pauses and
   // beats the block ignores; ignored beats do not count toward the total
   task automatic test_random_mix();
      int useful;
      int pick;
      int n;
      useful = 0;
      while (useful < MIX_ITEMS) begin
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
         if (pick < 66) begin
            n = $urandom_range(0, 99);
            if (n < 8) emit_bytes(7'(EMIT_LIMIT));
            else if (n < 16) emit_bytes(1);
            else if (n < 21) emit_bytes(7'($urandom_range(EMIT_LIMIT + 1, 127)));
            else emit_bytes(7'($urandom_range(1, EMIT_LIMIT)));
            useful++;
         end else if (pick < 80) begin
            write_seed(5'($urandom_range(0, SEED_COUNT - 1)), $urandom);
            useful++;
         end else if (pick < 85) begin
            commit_seed();
            useful++;
         end else if (pick < 87) begin
            reseed_table(1'b0);
            useful += SEED_COUNT + 1;
         end else if (pick < 89) begin
            wait_drained();
         end else if (pick < 93) begin
            send_request(ACT_UNUSED, 5'($urandom_range(0, 31)), $urandom,
                         7'($urandom_range(0, 127)));
         end else if (pick < 97) begin
            write_seed(5'($urandom_range(SEED_COUNT, 31)), $urandom);
         end else begin
            emit_bytes(0);
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin : main_sequence
      foreach (fill_table[i]) fill_table[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_long_stream();
      test_random_mix();
      wait_drained();
      // anything arriving now is a stray byte and is caught by the checker
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("run: %0d request beats, %0d emits, %0d commits, %0d table wraps",
               beats_sent, emits_sent, commits_sent, table_wraps);
      $display("run: %0d output bytes compared, %0d mismatches", bytes_checked, error_count);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // far beyond the slowest legal run
   initial begin : watchdog
      #(64_000_000);
      $display("timeout with %0d bytes still owed", expected_fill_bytes.size());
      $display("TB_ERROR");
      $finish;
   end

endmodule
